@@ rtl/core/ray_unit_cube_entry_macros.svh @@
// assertion macros for the ray cube entry block
`ifndef RAY_UNIT_CUBE_ENTRY_MACROS_SVH
`define RAY_UNIT_CUBE_ENTRY_MACROS_SVH

// same-cycle implication
`define RUCB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rucb assertion failed");

// next-cycle implication
`define RUCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rucb assertion failed");

`endif

@@ rtl/core/rucb_pkg.sv @@
package rucb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int POS_W     = 24;
    localparam int DIR_W     = 18;
    localparam int OUT_W     = 18;
    localparam int NUM_W     = POS_W + 1;
    localparam int MAG_W     = POS_W;
    localparam int DSR_W     = DIR_W;
    localparam int DVD_W     = MAG_W + FRAC_BITS;
    localparam int Q_W       = DVD_W;
    localparam int DIV_STEPS = Q_W;
    localparam int HALF_W    = Q_W / 2;
    localparam int PROD_W    = DIR_W + HALF_W + 1;
    localparam int SUM_W     = 60;
    localparam int ONE       = 1 << FRAC_BITS;

    localparam int IN_TDATA_W  = ((3 * POS_W + 3 * DIR_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((3 * OUT_W + 7) / 8) * 8;

    localparam logic signed [SUM_W-1:0] LIM2 =
        {{(SUM_W - 2 * FRAC_BITS - 1){1'b0}}, 1'b1, {(2 * FRAC_BITS){1'b0}}};

    typedef struct packed {
        logic [2:0][POS_W-1:0] o;
        logic [2:0][DIR_W-1:0] d;
    } ray_t;

    typedef struct packed {
        logic [2:0] cand;
        logic       in_cube;
    } flags_t;

    function automatic logic signed [PROD_W-1:0] mul_part(
        input logic signed [DIR_W-1:0] d,
        input logic [HALF_W-1:0]        u
    );
        logic signed [PROD_W-1:0] da;
        logic signed [PROD_W-1:0] ub;
        da = PROD_W'(d);
        ub = $signed(PROD_W'(u));
        return da * ub;
    endfunction

    function automatic logic signed [SUM_W-1:0] make_sum(
        input logic signed [PROD_W-1:0] ph,
        input logic signed [PROD_W-1:0] pl,
        input logic signed [POS_W-1:0]  o
    );
        logic signed [SUM_W-1:0] a;
        logic signed [SUM_W-1:0] b;
        logic signed [SUM_W-1:0] c;
        a = SUM_W'(ph);
        b = SUM_W'(pl);
        c = SUM_W'(o);
        return (a <<< HALF_W) + b + (c <<< FRAC_BITS);
    endfunction

    function automatic logic [OUT_W-1:0] clamp_one(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] one_s;
        one_s = SUM_W'(ONE);
        if (v > one_s)
        begin
            return OUT_W'(ONE);
        end
        if (v < -one_s)
        begin
            return OUT_W'(-ONE);
        end
        return OUT_W'(v);
    endfunction

endpackage

@@ rtl/core/rucb_div.sv @@
module rucb_div
    import rucb_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [MAG_W-1:0] mag,
    input  logic [DSR_W-1:0] dsr,
    output logic [Q_W-1:0]   quo
);

    logic [DSR_W-1:0] rem_reg [DIV_STEPS];
    logic [DSR_W-1:0] rem_next [DIV_STEPS];
    logic [DSR_W-1:0] dsr_reg [DIV_STEPS];
    logic [DVD_W-1:0] dvd_reg [DIV_STEPS];
    logic [DVD_W-1:0] dvd_next [DIV_STEPS];
    logic [Q_W-1:0]   q_reg [DIV_STEPS];
    logic [Q_W-1:0]   q_next [DIV_STEPS];

    logic [DSR_W-1:0] rem_in [DIV_STEPS];
    logic [DSR_W-1:0] dsr_in [DIV_STEPS];
    logic [DVD_W-1:0] dvd_in [DIV_STEPS];
    logic [Q_W-1:0]   q_in [DIV_STEPS];

    genvar s;
    generate
        for (s = 0; s < DIV_STEPS; s++)
        begin : g_step
            if (s == 0)
            begin : g_first
                assign rem_in[s] = '0;
                assign dsr_in[s] = dsr;
                assign dvd_in[s] = {mag, {FRAC_BITS{1'b0}}};
                assign q_in[s]   = '0;
            end
            else
            begin : g_rest
                assign rem_in[s] = rem_reg[s-1];
                assign dsr_in[s] = dsr_reg[s-1];
                assign dvd_in[s] = dvd_reg[s-1];
                assign q_in[s]   = q_reg[s-1];
            end

            always_comb
            begin : p_step
                logic [DSR_W:0] t;
                logic           ge;
                t  = {rem_in[s], dvd_in[s][DVD_W-1]};
                ge = (t >= {1'b0, dsr_in[s]});
                rem_next[s] = ge ? DSR_W'(t - {1'b0, dsr_in[s]}) : t[DSR_W-1:0];
                q_next[s]   = {q_in[s][Q_W-2:0], ge};
                dvd_next[s] = {dvd_in[s][DVD_W-2:0], 1'b0};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= rem_next[s];
                    dsr_reg[s] <= dsr_in[s];
                    dvd_reg[s] <= dvd_next[s];
                    q_reg[s]   <= q_next[s];
                end
            end
        end
    endgenerate

    assign quo = q_reg[DIV_STEPS-1];

endmodule

@@ rtl/core/ray_unit_cube_entry.sv @@
// Ray entry into the cube [-1,1]^3. One ray request is taken per cycle and one result
// leaves per cycle while the output is not stalled. The pipeline has one input register,
// a 40-stage restoring divider that resolves one quotient bit per stage for each axis,
// then five stages for the slab products, sums, slab test, nearest-face pick and final
// clamp. The whole pipeline advances whenever the output register is empty or being
// taken, so a stalled output holds every stage in place and nothing is lost or repeated.
module ray_unit_cube_entry
    import rucb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // start_x, start_y, start_z, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // hit
    output logic [0:0]             m_axis_tuser
);

    logic en;

    logic   in_valid_reg;
    ray_t   in_reg;
    ray_t   in_next;

    logic signed [NUM_W-1:0] num_c [3];
    logic [MAG_W-1:0]        mag_c [3];
    logic [DSR_W-1:0]        dsr_c [3];
    flags_t                  flags_c;

    logic   div_valid_reg [DIV_STEPS];
    ray_t   div_ray_reg [DIV_STEPS];
    flags_t div_flags_reg [DIV_STEPS];
    logic [Q_W-1:0] quo [3];

    logic                     m1_valid_reg;
    ray_t                     m1_ray_reg;
    flags_t                   m1_flags_reg;
    logic [Q_W-1:0]           m1_u_reg [3];
    logic signed [PROD_W-1:0] m1_ph_reg [3][3];
    logic signed [PROD_W-1:0] m1_pl_reg [3][3];

    logic                    m2_valid_reg;
    ray_t                    m2_ray_reg;
    flags_t                  m2_flags_reg;
    logic [Q_W-1:0]          m2_u_reg [3];
    logic signed [SUM_W-1:0] m2_s_reg [3][3];

    logic                    m3_valid_reg;
    ray_t                    m3_ray_reg;
    flags_t                  m3_flags_reg;
    logic [Q_W-1:0]          m3_u_reg [3];
    logic signed [SUM_W-1:0] m3_s_reg [3][3];
    logic [2:0]              m3_ok_reg;
    logic [2:0]              m3_ok_next;

    logic                    m4_valid_reg;
    ray_t                    m4_ray_reg;
    flags_t                  m4_flags_reg;
    logic signed [SUM_W-1:0] m4_s_reg [3][3];
    logic [1:0]              m4_idx_reg;
    logic [1:0]              m4_idx_next;
    logic                    m4_found_reg;
    logic                    m4_found_next;

    logic                   out_valid_reg;
    logic [3*OUT_W-1:0]     out_data_reg;
    logic [3*OUT_W-1:0]     out_data_next;
    logic                   out_hit_reg;
    logic                   out_hit_next;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 3 * OUT_W){1'b0}}, out_data_reg};
    assign m_axis_tuser  = out_hit_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            in_next.o[k] = s_axis_tdata[k*POS_W +: POS_W];
            in_next.d[k] = s_axis_tdata[3*POS_W + k*DIR_W +: DIR_W];
        end
    end

    // entry face distance numerators, divider operands, candidate and in-cube flags
    always_comb
    begin
        flags_c.in_cube = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            if ($signed(in_reg.d[k]) < 0)
            begin
                num_c[k] = NUM_W'(ONE) - NUM_W'($signed(in_reg.o[k]));
            end
            else
            begin
                num_c[k] = -NUM_W'(ONE) - NUM_W'($signed(in_reg.o[k]));
            end
            mag_c[k] = (num_c[k] < 0) ? MAG_W'(-num_c[k]) : MAG_W'(num_c[k]);
            dsr_c[k] = ($signed(in_reg.d[k]) < 0) ? DSR_W'(-$signed(in_reg.d[k]))
                                                  : in_reg.d[k];
            flags_c.cand[k] = (in_reg.d[k] != '0) &&
                              ((num_c[k] == '0) ||
                               ((num_c[k] < 0) == ($signed(in_reg.d[k]) < 0)));
            if (($signed(in_reg.o[k]) > POS_W'(ONE)) ||
                ($signed(in_reg.o[k]) < -POS_W'(ONE)))
            begin
                flags_c.in_cube = 1'b0;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_div
            rucb_div u_div (
                .clk (clk),
                .en  (en),
                .mag (mag_c[g]),
                .dsr (dsr_c[g]),
                .quo (quo[g])
            );
        end
    endgenerate

    always_comb
    begin
        m3_ok_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            m3_ok_next[i] = m2_flags_reg.cand[i];
            for (int k = 0; k < 3; k++)
            begin
                if ((k != i) && ((m2_s_reg[i][k] > LIM2) || (m2_s_reg[i][k] < -LIM2)))
                begin
                    m3_ok_next[i] = 1'b0;
                end
            end
        end
    end

    // nearest surviving face, lowest axis on ties
    always_comb
    begin
        logic [Q_W-1:0] best;
        best          = '0;
        m4_idx_next   = '0;
        m4_found_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (m3_ok_reg[i] && (!m4_found_next || (m3_u_reg[i] < best)))
            begin
                best          = m3_u_reg[i];
                m4_idx_next   = 2'(i);
                m4_found_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        out_hit_next = m4_flags_reg.in_cube || m4_found_reg;
        for (int k = 0; k < 3; k++)
        begin
            if (m4_flags_reg.in_cube)
            begin
                out_data_next[k*OUT_W +: OUT_W] = OUT_W'($signed(m4_ray_reg.o[k]));
            end
            else if (m4_found_reg)
            begin
                out_data_next[k*OUT_W +: OUT_W] =
                    clamp_one(m4_s_reg[m4_idx_reg][k] >>> FRAC_BITS);
            end
            else if ($signed(m4_ray_reg.d[k]) > 0)
            begin
                out_data_next[k*OUT_W +: OUT_W] = OUT_W'(ONE);
            end
            else if ($signed(m4_ray_reg.d[k]) < 0)
            begin
                out_data_next[k*OUT_W +: OUT_W] = OUT_W'(-ONE);
            end
            else
            begin
                out_data_next[k*OUT_W +: OUT_W] =
                    clamp_one(SUM_W'($signed(m4_ray_reg.o[k])));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                div_valid_reg[s] <= 1'b0;
            end
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            m3_valid_reg  <= 1'b0;
            m4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg     <= s_axis_tvalid;
            div_valid_reg[0] <= in_valid_reg;
            for (int s = 1; s < DIV_STEPS; s++)
            begin
                div_valid_reg[s] <= div_valid_reg[s-1];
            end
            m1_valid_reg  <= div_valid_reg[DIV_STEPS-1];
            m2_valid_reg  <= m1_valid_reg;
            m3_valid_reg  <= m2_valid_reg;
            m4_valid_reg  <= m3_valid_reg;
            out_valid_reg <= m4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg           <= in_next;
            div_ray_reg[0]   <= in_reg;
            div_flags_reg[0] <= flags_c;
            for (int s = 1; s < DIV_STEPS; s++)
            begin
                div_ray_reg[s]   <= div_ray_reg[s-1];
                div_flags_reg[s] <= div_flags_reg[s-1];
            end

            m1_ray_reg   <= div_ray_reg[DIV_STEPS-1];
            m1_flags_reg <= div_flags_reg[DIV_STEPS-1];
            for (int i = 0; i < 3; i++)
            begin
                m1_u_reg[i] <= quo[i];
                for (int k = 0; k < 3; k++)
                begin
                    m1_ph_reg[i][k] <= mul_part($signed(div_ray_reg[DIV_STEPS-1].d[k]),
                                                quo[i][Q_W-1:HALF_W]);
                    m1_pl_reg[i][k] <= mul_part($signed(div_ray_reg[DIV_STEPS-1].d[k]),
                                                quo[i][HALF_W-1:0]);
                end
            end

            m2_ray_reg   <= m1_ray_reg;
            m2_flags_reg <= m1_flags_reg;
            for (int i = 0; i < 3; i++)
            begin
                m2_u_reg[i] <= m1_u_reg[i];
                for (int k = 0; k < 3; k++)
                begin
                    m2_s_reg[i][k] <= make_sum(m1_ph_reg[i][k], m1_pl_reg[i][k],
                                               $signed(m1_ray_reg.o[k]));
                end
            end

            m3_ray_reg   <= m2_ray_reg;
            m3_flags_reg <= m2_flags_reg;
            m3_ok_reg    <= m3_ok_next;
            for (int i = 0; i < 3; i++)
            begin
                m3_u_reg[i] <= m2_u_reg[i];
                for (int k = 0; k < 3; k++)
                begin
                    m3_s_reg[i][k] <= m2_s_reg[i][k];
                end
            end

            m4_ray_reg   <= m3_ray_reg;
            m4_flags_reg <= m3_flags_reg;
            m4_idx_reg   <= m4_idx_next;
            m4_found_reg <= m4_found_next;
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    m4_s_reg[i][k] <= m3_s_reg[i][k];
                end
            end

            out_data_reg <= out_data_next;
            out_hit_reg  <= out_hit_next;
        end
    end

endmodule

@@ rtl/core/rucb_chk.sv @@
`include "ray_unit_cube_entry_macros.svh"

module rucb_chk
    import rucb_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]             m_axis_tuser
);

    logic out_wait;
    logic coord_ok;

    assign out_wait = m_axis_tvalid && !m_axis_tready;
    assign coord_ok = ($signed(m_axis_tdata[17:0]) <= ONE) &&
                      ($signed(m_axis_tdata[17:0]) >= -ONE) &&
                      ($signed(m_axis_tdata[35:18]) <= ONE) &&
                      ($signed(m_axis_tdata[35:18]) >= -ONE) &&
                      ($signed(m_axis_tdata[53:36]) <= ONE) &&
                      ($signed(m_axis_tdata[53:36]) >= -ONE);

    `RUCB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, m_axis_tvalid)

    `RUCB_ASSERT_NEXT(a_data_stable, clk, rst_n, out_wait, $stable(m_axis_tdata))

    `RUCB_ASSERT_NEXT(a_hit_stable, clk, rst_n, out_wait, $stable(m_axis_tuser))

    `RUCB_ASSERT_NOW(a_ready_free, clk, rst_n, !m_axis_tvalid || m_axis_tready, s_axis_tready)

    `RUCB_ASSERT_NOW(a_range, clk, rst_n, m_axis_tvalid, coord_ok)

endmodule

bind ray_unit_cube_entry rucb_chk u_rucb_chk (.*);
